// File: hw/rtl/acsw_pkg.sv
// Shared types, constants and helpers of the adaptive clap counter switch.
`default_nettype none
package acsw_pkg;

   localparam int INIT_SHIFT  = 13;
   localparam int ADC_BITS    = 10;
   localparam int LEVEL_W     = 30;
   localparam int FRAC_BITS   = LEVEL_W - ADC_BITS;
   localparam int SEED_W      = ADC_BITS + INIT_SHIFT;
   localparam int PCT_W       = 7;
   localparam int ALPHA_W     = 5;
   localparam int DEB_W       = 8;
   localparam int WIN_W       = 16;
   localparam int CLAP_W      = 7;
   localparam int FACTOR_W    = 8;
   localparam int PROD_W      = LEVEL_W + FACTOR_W;
   localparam int ACTION_W    = 2;
   localparam int SAMPLE_W    = 10;
   localparam int PHASE_W     = 3;
   localparam int AMB_W       = 10;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 16;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   typedef enum logic [ACTION_W-1:0] {
      ACT_SAMPLE = 2'd0,
      ACT_TICK   = 2'd1,
      ACT_TOGGLE = 2'd2,
      ACT_NONE   = 2'd3
   } action_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PERCENT  = 3'd0,
      CSR_ALPHA    = 3'd1,
      CSR_DEBOUNCE = 3'd2,
      CSR_WINDOW   = 3'd3,
      CSR_CLAPS    = 3'd4
   } csr_index_type;

   typedef enum logic [4:0] {
      PH_SEED = 5'b00001,
      PH_IDLE = 5'b00010,
      PH_DEB1 = 5'b00100,
      PH_WIN  = 5'b01000,
      PH_DEB2 = 5'b10000
   } phase_type;

   localparam logic [PHASE_W-1:0] CODE_SEED = 3'd0;
   localparam logic [PHASE_W-1:0] CODE_IDLE = 3'd1;
   localparam logic [PHASE_W-1:0] CODE_DEB1 = 3'd2;
   localparam logic [PHASE_W-1:0] CODE_WIN  = 3'd3;
   localparam logic [PHASE_W-1:0] CODE_DEB2 = 3'd4;

   typedef struct packed {
      logic                is_sample;
      logic                is_tick;
      logic                is_toggle;
      logic [ADC_BITS-1:0] sample;
   } item_type;

   typedef struct packed {
      logic [PCT_W-1:0]   percent_above;
      logic [ALPHA_W-1:0] alpha_shift;
      logic [DEB_W-1:0]   debounce_ms;
      logic [WIN_W-1:0]   window_ms;
      logic [CLAP_W-1:0]  claps_needed;
   } cfg_type;

   function automatic logic [ADC_BITS-1:0] mask_sample(input logic [SAMPLE_W-1:0] s);
      logic [ADC_BITS+SAMPLE_W-1:0] wide;
      wide = {{ADC_BITS{1'b0}}, s};
      return wide[ADC_BITS-1:0];
   endfunction

endpackage
`default_nettype wire

// File: hw/rtl/adaptive_clap_counter_switch_top.sv
// Top level of the adaptive clap counter switch: control registers and the two halves.
//
// Usage: each req_ transaction carries an action (audio sample, millisecond
// tick or manual toggle) and a sample value. Every transaction yields exactly
// one rsp_ transaction with the toggle pulse, switch state, clap count, phase
// and integer ambient level after that transaction.
// Throughput: one transaction per cycle on both sides while rsp_stall is low.
// Path: an accepted transaction passes through the two-entry queue and then
// the result register before it can leave. The loop that sets the throughput
// is the state update of the back end. Control registers are written over the
// csr_ port, always ready; the user must write them only while the block is
// idle, the block itself does not enforce this. Reset restores the register
// defaults, empties the queue and returns to seeding, where the first 2^13
// samples set the ambient level. When the receiver raises rsp_stall the result
// holds, the queue fills and req_stall rises once both queue entries are taken.
`default_nettype none
module adaptive_clap_counter_switch_top (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              req_valid,
   output logic                             req_stall,
   input  wire  [acsw_pkg::ACTION_W-1:0]    req_action,
   input  wire  [acsw_pkg::SAMPLE_W-1:0]    req_sample,
   output logic                             rsp_valid,
   input  wire                              rsp_stall,
   output logic                             rsp_toggle_pulse,
   output logic                             rsp_switch_on,
   output logic [acsw_pkg::CLAP_W-1:0]      rsp_clap_total,
   output logic [acsw_pkg::PHASE_W-1:0]     rsp_phase_now,
   output logic [acsw_pkg::AMB_W-1:0]       rsp_ambient_level,
   input  wire                              csr_valid,
   output logic                             csr_ready,
   input  wire  [acsw_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire  [acsw_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import acsw_pkg::*;

   cfg_type  cfg_ff, cfg_in;
   logic     q_valid;
   item_type q_item;
   logic     q_pop;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index_type'(csr_index))
            CSR_PERCENT:  cfg_in.percent_above = csr_wdata[PCT_W-1:0];
            CSR_ALPHA:    cfg_in.alpha_shift   = csr_wdata[ALPHA_W-1:0];
            CSR_DEBOUNCE: cfg_in.debounce_ms   = csr_wdata[DEB_W-1:0];
            CSR_WINDOW:   cfg_in.window_ms     = csr_wdata[WIN_W-1:0];
            CSR_CLAPS:    cfg_in.claps_needed  = csr_wdata[CLAP_W-1:0];
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.percent_above <= PCT_W'(30);
         cfg_ff.alpha_shift   <= ALPHA_W'(14);
         cfg_ff.debounce_ms   <= DEB_W'(30);
         cfg_ff.window_ms     <= WIN_W'(2000);
         cfg_ff.claps_needed  <= CLAP_W'(2);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   acsw_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_action (req_action),
      .req_sample (req_sample),
      .q_valid    (q_valid),
      .q_item     (q_item),
      .q_pop      (q_pop)
   );

   acsw_back u_back (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg_ff),
      .q_valid           (q_valid),
      .q_item            (q_item),
      .q_pop             (q_pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_toggle_pulse  (rsp_toggle_pulse),
      .rsp_switch_on     (rsp_switch_on),
      .rsp_clap_total    (rsp_clap_total),
      .rsp_phase_now     (rsp_phase_now),
      .rsp_ambient_level (rsp_ambient_level)
   );

endmodule
`default_nettype wire

// File: hw/rtl/acsw_front.sv
// Front end: accepts transactions, decodes the action and queues them.
`default_nettype none
module acsw_front (
   input  wire                            clock,
   input  wire                            reset,
   input  wire                            req_valid,
   output logic                           req_stall,
   input  wire  [acsw_pkg::ACTION_W-1:0]  req_action,
   input  wire  [acsw_pkg::SAMPLE_W-1:0]  req_sample,
   output logic                           q_valid,
   output acsw_pkg::item_type             q_item,
   input  wire                            q_pop
);
   import acsw_pkg::*;

   item_type             q_mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]      count_ff, count_in;
   logic                 push;
   logic                 pop;
   item_type             item_new;

   assign req_stall = (count_ff == (QPTR_W+1)'(QUEUE_DEPTH));
   assign push      = req_valid && !req_stall;
   assign q_valid   = (count_ff != '0);
   assign pop       = q_pop && q_valid;
   assign q_item    = q_mem_ff[rd_ptr_ff];

   always_comb begin
      item_new.is_sample = (action_type'(req_action) == ACT_SAMPLE);
      item_new.is_tick   = (action_type'(req_action) == ACT_TICK);
      item_new.is_toggle = (action_type'(req_action) == ACT_TOGGLE);
      item_new.sample    = mask_sample(req_sample);
   end

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_mem_ff[wr_ptr_ff] <= item_new;
      end
   end

endmodule
`default_nettype wire

// File: hw/rtl/acsw_back.sv
// Back end: level tracking, clap detection, window judging and result register.
`default_nettype none
module acsw_back (
   input  wire                            clock,
   input  wire                            reset,
   input  acsw_pkg::cfg_type              cfg,
   input  wire                            q_valid,
   input  acsw_pkg::item_type             q_item,
   output logic                           q_pop,
   output logic                           rsp_valid,
   input  wire                            rsp_stall,
   output logic                           rsp_toggle_pulse,
   output logic                           rsp_switch_on,
   output logic [acsw_pkg::CLAP_W-1:0]    rsp_clap_total,
   output logic [acsw_pkg::PHASE_W-1:0]   rsp_phase_now,
   output logic [acsw_pkg::AMB_W-1:0]     rsp_ambient_level
);
   import acsw_pkg::*;

   phase_type             phase_ff, phase_in;
   logic [LEVEL_W-1:0]    level_ff, level_in;
   logic [SEED_W-1:0]     seed_sum_ff, seed_sum_in;
   logic [INIT_SHIFT-1:0] seed_cnt_ff, seed_cnt_in;
   logic [WIN_W-1:0]      elapsed_ff, elapsed_in;
   logic [DEB_W-1:0]      deb_ff, deb_in;
   logic [CLAP_W-1:0]     tally_ff, tally_in;
   logic                  switch_ff, switch_in;
   logic                  pulse;

   logic                  rsp_valid_ff;
   logic                  pulse_ff;
   logic                  sw_out_ff;
   logic [CLAP_W-1:0]     tally_out_ff;
   logic [PHASE_W-1:0]    phase_out_ff;
   logic [AMB_W-1:0]      amb_out_ff;

   logic                  take;
   logic [ADC_BITS-1:0]   x;
   logic [LEVEL_W-1:0]    target;
   logic [LEVEL_W-1:0]    avg_next;
   logic [LEVEL_W-1:0]    chk_level;
   logic [FACTOR_W-1:0]   factor;
   logic [PROD_W-1:0]     rhs;
   logic [PROD_W-1:0]     lhs;
   logic [ADC_BITS+6:0]   x_scaled;
   logic                  loud;
   logic [SEED_W-1:0]     seed_total;
   logic [SEED_W+FRAC_BITS-1:0] seed_wide;
   logic [ADC_BITS-1:0]   lvl_int;
   logic [ADC_BITS+AMB_W-1:0] lvl_wide;
   logic [AMB_W-1:0]      amb;
   logic [PHASE_W-1:0]    code;

   assign take  = q_valid && (!rsp_valid_ff || !rsp_stall);
   assign q_pop = take;
   assign x     = q_item.sample;

   // moving average step toward the new sample
   always_comb begin
      target = {x, {FRAC_BITS{1'b0}}};
      if (target >= level_ff) begin
         avg_next = level_ff + ((target - level_ff) >> cfg.alpha_shift);
      end else begin
         avg_next = level_ff - ((level_ff - target) >> cfg.alpha_shift);
      end
   end

   // loudness compare against the level the phase uses
   always_comb begin
      chk_level = (phase_ff inside {PH_IDLE, PH_WIN}) ? avg_next : level_ff;
      factor    = FACTOR_W'(7'd100) + FACTOR_W'(cfg.percent_above);
      rhs       = PROD_W'(chk_level) * PROD_W'(factor);
      x_scaled  = (ADC_BITS+7)'(x) * (ADC_BITS+7)'(7'd100);
      lhs       = PROD_W'({x_scaled, {FRAC_BITS{1'b0}}});
      loud      = lhs > rhs;
   end

   always_comb begin
      seed_total = seed_sum_ff + SEED_W'(x);
      seed_wide  = {seed_total, {FRAC_BITS{1'b0}}};
   end

   always_comb begin
      phase_in    = phase_ff;
      level_in    = level_ff;
      seed_sum_in = seed_sum_ff;
      seed_cnt_in = seed_cnt_ff;
      elapsed_in  = elapsed_ff;
      deb_in      = deb_ff;
      tally_in    = tally_ff;
      switch_in   = switch_ff;
      pulse       = 1'b0;
      if (take) begin
         if (q_item.is_toggle) begin
            switch_in = ~switch_ff;
            pulse     = 1'b1;
         end else if (q_item.is_sample) begin
            case (phase_ff)
               PH_SEED: begin
                  seed_sum_in = seed_total;
                  seed_cnt_in = seed_cnt_ff + 1'b1;
                  if (&seed_cnt_ff) begin
                     level_in = seed_wide[INIT_SHIFT +: LEVEL_W];
                     phase_in = PH_IDLE;
                  end
               end
               PH_IDLE: begin
                  level_in = avg_next;
                  if (loud) begin
                     elapsed_in = '0;
                     deb_in     = cfg.debounce_ms;
                     phase_in   = PH_DEB1;
                  end
               end
               PH_DEB1, PH_DEB2: begin
                  if (deb_ff == '0) begin
                     if (loud) begin
                        tally_in = '0;
                        phase_in = PH_IDLE;
                     end else begin
                        if (tally_ff != {CLAP_W{1'b1}}) begin
                           tally_in = tally_ff + 1'b1;
                        end
                        phase_in = PH_WIN;
                     end
                  end
               end
               PH_WIN: begin
                  if (elapsed_ff < cfg.window_ms) begin
                     level_in = avg_next;
                     if (loud) begin
                        deb_in   = cfg.debounce_ms;
                        phase_in = PH_DEB2;
                     end
                  end
               end
               default: begin
                  phase_in = PH_IDLE;
               end
            endcase
         end else if (q_item.is_tick) begin
            if (phase_ff inside {PH_DEB1, PH_WIN, PH_DEB2}) begin
               if (elapsed_ff != {WIN_W{1'b1}}) begin
                  elapsed_in = elapsed_ff + 1'b1;
               end
               if (phase_ff != PH_WIN && deb_ff != '0) begin
                  deb_in = deb_ff - 1'b1;
               end
            end
         end
         // judge the count at window end
         if ((q_item.is_sample || q_item.is_tick) && phase_in == PH_WIN &&
             elapsed_in >= cfg.window_ms) begin
            if (tally_in >= cfg.claps_needed) begin
               switch_in = ~switch_in;
               pulse     = 1'b1;
            end
            tally_in = '0;
            phase_in = PH_IDLE;
         end
      end
   end

   always_comb begin
      lvl_int  = level_in[LEVEL_W-1:FRAC_BITS];
      lvl_wide = {{AMB_W{1'b0}}, lvl_int};
      if (lvl_wide > (ADC_BITS+AMB_W)'({AMB_W{1'b1}})) begin
         amb = {AMB_W{1'b1}};
      end else begin
         amb = lvl_wide[AMB_W-1:0];
      end
      case (phase_in)
         PH_SEED: code = CODE_SEED;
         PH_IDLE: code = CODE_IDLE;
         PH_DEB1: code = CODE_DEB1;
         PH_WIN:  code = CODE_WIN;
         PH_DEB2: code = CODE_DEB2;
         default: code = CODE_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_SEED;
         level_ff     <= '0;
         seed_sum_ff  <= '0;
         seed_cnt_ff  <= '0;
         elapsed_ff   <= '0;
         deb_ff       <= '0;
         tally_ff     <= '0;
         switch_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         level_ff     <= level_in;
         seed_sum_ff  <= seed_sum_in;
         seed_cnt_ff  <= seed_cnt_in;
         elapsed_ff   <= elapsed_in;
         deb_ff       <= deb_in;
         tally_ff     <= tally_in;
         switch_ff    <= switch_in;
         if (take) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         pulse_ff     <= pulse;
         sw_out_ff    <= switch_in;
         tally_out_ff <= tally_in;
         phase_out_ff <= code;
         amb_out_ff   <= amb;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_toggle_pulse  = pulse_ff;
   assign rsp_switch_on     = sw_out_ff;
   assign rsp_clap_total    = tally_out_ff;
   assign rsp_phase_now     = phase_out_ff;
   assign rsp_ambient_level = amb_out_ff;

endmodule
`default_nettype wire

// File: test/tb.sv
// Self-checking testbench for the adaptive clap counter switch top level.
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import acsw_pkg::*;

   typedef struct packed {
      logic                toggle_pulse;
      logic                switch_on;
      logic [CLAP_W-1:0]   clap_total;
      logic [PHASE_W-1:0]  phase_now;
      logic [AMB_W-1:0]    ambient_level;
   } switch_report_type;

   typedef enum logic [1:0] {SMP_FIXED, SMP_RAND, SMP_LOUD, SMP_QUIET} sample_kind_type;

   typedef struct packed {
      action_type        act;
      sample_kind_type   kind;
      logic [SAMPLE_W-1:0] smp;
      int unsigned       reps;
      logic              typed;
      switch_report_type want;
   } stim_row_type;

   typedef enum logic [1:0] {FLOW, LIGHT, HEAVY, ALTERNATE} stall_style_type;

   localparam int NROWS = 22;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic [ACTION_W-1:0] req_action = ACT_SAMPLE;
   logic [SAMPLE_W-1:0] req_sample = '0;
   logic rsp_stall = 1'b0;
   logic csr_valid = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_PERCENT;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;
   logic req_stall, rsp_valid, csr_ready;
   logic rsp_toggle_pulse, rsp_switch_on;
   logic [CLAP_W-1:0] rsp_clap_total;
   logic [PHASE_W-1:0] rsp_phase_now;
   logic [AMB_W-1:0] rsp_ambient_level;

   // predicted block state and register copy
   cfg_type regs = '{7'd30, 5'd14, 8'd30, 16'd2000, 7'd2};
   logic [PHASE_W-1:0] ph = CODE_SEED;
   logic [LEVEL_W-1:0] lvl_acc = '0;
   logic [SEED_W-1:0] seed_acc = '0;
   logic [INIT_SHIFT:0] seed_n = '0;
   logic [WIN_W-1:0] win_ticks = '0;
   logic [DEB_W-1:0] deb_ticks = '0;
   logic [CLAP_W-1:0] claps = '0;
   logic sw = 1'b0;

   switch_report_type reports_due[$];
   switch_report_type head;
   int unsigned errors = 0;
   int unsigned items_sent = 0;
   int unsigned settings_written = 0;
   int unsigned toggles_seen = 0;
   int unsigned peak_claps = 0;
   logic [7:0] phases_seen = '0;
   int unsigned burst_left = 0;
   stall_style_type stall_style = FLOW;
   int unsigned style_left = 0;

   stim_row_type plan [NROWS] = '{
      '{ACT_TICK,   SMP_FIXED, 10'd0,    1, 1'b1, '{1'b0, 1'b0, 7'd0, CODE_SEED, 10'd0}},
      '{ACT_SAMPLE, SMP_FIXED, 10'd1023, 1, 1'b1, '{1'b0, 1'b0, 7'd0, CODE_SEED, 10'd0}},
      '{ACT_SAMPLE, SMP_FIXED, 10'd0,    1, 1'b1, '{1'b0, 1'b0, 7'd0, CODE_SEED, 10'd0}},
      '{ACT_TOGGLE, SMP_FIXED, 10'h2AA,  1, 1'b1, '{1'b1, 1'b1, 7'd0, CODE_SEED, 10'd0}},
      '{ACT_NONE,   SMP_FIXED, 10'h155,  1, 1'b1, '{1'b0, 1'b1, 7'd0, CODE_SEED, 10'd0}},
      '{ACT_TOGGLE, SMP_FIXED, 10'd1023, 1, 1'b1, '{1'b1, 1'b0, 7'd0, CODE_SEED, 10'd0}},
      '{ACT_NONE,   SMP_FIXED, 10'd0,    1, 1'b1, '{1'b0, 1'b0, 7'd0, CODE_SEED, 10'd0}},
      '{ACT_TICK,   SMP_FIXED, 10'd1023, 1, 1'b1, '{1'b0, 1'b0, 7'd0, CODE_SEED, 10'd0}},
      '{ACT_SAMPLE, SMP_RAND,  10'd0, (1 << INIT_SHIFT) - 3, 1'b0, '0},
      '{ACT_SAMPLE, SMP_FIXED, 10'd1023, 1, 1'b0, '0},
      '{ACT_SAMPLE, SMP_LOUD,  10'd0,    1, 1'b0, '0},
      '{ACT_TICK,   SMP_FIXED, 10'h3FF,  2, 1'b0, '0},
      '{ACT_SAMPLE, SMP_QUIET, 10'd0,    1, 1'b0, '0},
      '{ACT_SAMPLE, SMP_LOUD,  10'd0,    1, 1'b0, '0},
      '{ACT_SAMPLE, SMP_FIXED, 10'd0,    1, 1'b0, '0},
      '{ACT_TICK,   SMP_FIXED, 10'd0,    2, 1'b0, '0},
      '{ACT_SAMPLE, SMP_QUIET, 10'd0,    1, 1'b0, '0},
      '{ACT_TICK,   SMP_FIXED, 10'h2AA, 12, 1'b0, '0},
      '{ACT_SAMPLE, SMP_LOUD,  10'd0,    1, 1'b0, '0},
      '{ACT_TICK,   SMP_FIXED, 10'h155,  2, 1'b0, '0},
      '{ACT_SAMPLE, SMP_LOUD,  10'd0,    1, 1'b0, '0},
      '{ACT_TOGGLE, SMP_FIXED, 10'd0,    1, 1'b0, '0}
   };

   adaptive_clap_counter_switch_top uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_action        (req_action),
      .req_sample        (req_sample),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_toggle_pulse  (rsp_toggle_pulse),
      .rsp_switch_on     (rsp_switch_on),
      .rsp_clap_total    (rsp_clap_total),
      .rsp_phase_now     (rsp_phase_now),
      .rsp_ambient_level (rsp_ambient_level),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   always #1 clock = ~clock;

   initial begin
      #6_000_000;
      $display("** adaptive_clap_counter_switch_top: FAILED **");
      $finish;
   end

   function automatic void track_level(logic [ADC_BITS-1:0] x);
      logic [63:0] target;
      logic [63:0] cur;
      target = 64'(x) << FRAC_BITS;
      cur = 64'(lvl_acc);
      if (target >= cur) begin
         lvl_acc = LEVEL_W'(cur + ((target - cur) >> regs.alpha_shift));
      end else begin
         lvl_acc = LEVEL_W'(cur - ((cur - target) >> regs.alpha_shift));
      end
   endfunction

   function automatic logic over_threshold(logic [ADC_BITS-1:0] x);
      return ((64'(x) * 64'd100) << FRAC_BITS) >
             (64'(lvl_acc) * (64'd100 + 64'(regs.percent_above)));
   endfunction

   function automatic switch_report_type predict_report(action_type act,
                                                        logic [SAMPLE_W-1:0] smp);
      switch_report_type r;
      logic [ADC_BITS-1:0] x;
      logic [63:0] amb;
      logic pulse;
      x = smp[ADC_BITS-1:0];
      pulse = 1'b0;
      case (act)
         ACT_TOGGLE: begin
            sw = ~sw;
            pulse = 1'b1;
         end
         ACT_SAMPLE: begin
            case (ph)
               CODE_SEED: begin
                  seed_acc = seed_acc + SEED_W'(x);
                  seed_n = seed_n + 1'b1;
                  if (32'(seed_n) >= (1 << INIT_SHIFT)) begin
                     lvl_acc = LEVEL_W'((64'(seed_acc) << FRAC_BITS) >> INIT_SHIFT);
                     ph = CODE_IDLE;
                  end
               end
               CODE_IDLE: begin
                  track_level(x);
                  if (over_threshold(x)) begin
                     win_ticks = '0;
                     deb_ticks = regs.debounce_ms;
                     ph = CODE_DEB1;
                  end
               end
               CODE_DEB1, CODE_DEB2: begin
                  if (deb_ticks == '0) begin
                     if (over_threshold(x)) begin
                        claps = '0;
                        ph = CODE_IDLE;
                     end else begin
                        if (claps != '1) claps = claps + 1'b1;
                        ph = CODE_WIN;
                     end
                  end
               end
               CODE_WIN: begin
                  if (win_ticks < regs.window_ms) begin
                     track_level(x);
                     if (over_threshold(x)) begin
                        deb_ticks = regs.debounce_ms;
                        ph = CODE_DEB2;
                     end
                  end
               end
               default: ph = CODE_IDLE;
            endcase
         end
         ACT_TICK: begin
            if (ph >= CODE_DEB1 && ph <= CODE_DEB2) begin
               if (win_ticks != '1) win_ticks = win_ticks + 1'b1;
               if (ph != CODE_WIN && deb_ticks != '0) deb_ticks = deb_ticks - 1'b1;
            end
         end
         default: ;
      endcase
      if ((act == ACT_SAMPLE || act == ACT_TICK) && ph == CODE_WIN &&
          win_ticks >= regs.window_ms) begin
         if (claps >= regs.claps_needed) begin
            sw = ~sw;
            pulse = 1'b1;
         end
         claps = '0;
         ph = CODE_IDLE;
      end
      amb = 64'(lvl_acc) >> FRAC_BITS;
      if (amb > 64'({AMB_W{1'b1}})) amb = 64'({AMB_W{1'b1}});
      r.toggle_pulse = pulse;
      r.switch_on = sw;
      r.clap_total = claps;
      r.phase_now = ph;
      r.ambient_level = amb[AMB_W-1:0];
      return r;
   endfunction

   // loud values sit above the current threshold, or are 1023 if it is 1023 or more; quiet ones at or below it
   function automatic logic [SAMPLE_W-1:0] pick_sample(logic want_loud);
      logic [63:0] thr;
      thr = (64'(lvl_acc) * (64'd100 + 64'(regs.percent_above))) /
            (64'd100 << FRAC_BITS);
      if (thr >= 64'd1023) begin
         if (want_loud) return 10'd1023;
         return 10'($urandom_range(1023, 0));
      end
      if (want_loud) return 10'($urandom_range(1023, 32'(thr) + 1));
      return 10'($urandom_range(32'(thr), 0));
   endfunction

   function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         errors++;
      end
   endfunction

   // called at a falling edge; returns at the falling edge after acceptance
   task automatic send_action(action_type act, logic [SAMPLE_W-1:0] smp,
                              logic typed = 1'b0, switch_report_type want = '0);
      int unsigned gap;
      switch_report_type got;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         burst_left = $urandom_range(1, 20);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_action <= act;
      req_sample <= smp;
      do @(posedge clock); while (req_stall);
      got = predict_report(act, smp);
      reports_due.push_back(typed ? want : got);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_PERCENT:  regs.percent_above = data[PCT_W-1:0];
         CSR_ALPHA:    regs.alpha_shift = data[ALPHA_W-1:0];
         CSR_DEBOUNCE: regs.debounce_ms = data[DEB_W-1:0];
         CSR_WINDOW:   regs.window_ms = data[WIN_W-1:0];
         CSR_CLAPS:    regs.claps_needed = data[CLAP_W-1:0];
         default: ;
      endcase
      @(negedge clock);
   endtask

   // junk above each register's width (none fits above the 16-bit window), then one write to an unmapped index
   task automatic write_setting(int unsigned pct, int unsigned alpha, int unsigned deb,
                                int unsigned win, int unsigned need);
      int unsigned vals [5];
      int unsigned widths [5];
      csr_index_type slots [5];
      vals = '{pct, alpha, deb, win, need};
      widths = '{PCT_W, ALPHA_W, DEB_W, WIN_W, CLAP_W};
      slots = '{CSR_PERCENT, CSR_ALPHA, CSR_DEBOUNCE, CSR_WINDOW, CSR_CLAPS};
      for (int i = 0; i < 5; i++) begin
         csr_write(slots[i], 16'((64'($urandom) << widths[i]) | 64'(vals[i])));
      end
      csr_write(3'(CSR_CLAPS) + 3'($urandom_range(1, 3)), 16'($urandom));
      csr_valid <= 1'b0;
      settings_written++;
   endtask

   task automatic settle();
      int unsigned waited;
      waited = 0;
      req_valid <= 1'b0;
      while (reports_due.size() != 0 && waited < 5000) begin
         @(negedge clock);
         waited++;
      end
      repeat (4) @(negedge clock);
   endtask

   task automatic run_out_debounce();
      while (deb_ticks != '0) send_action(ACT_TICK, 10'($urandom));
      if ($urandom_range(0, 3) == 0) begin
         repeat ($urandom_range(1, 2)) send_action(ACT_TICK, 10'($urandom));
      end
   endtask

   task automatic finish_window();
      while (ph != CODE_IDLE) begin
         if (ph == CODE_WIN || deb_ticks != '0) begin
            send_action(ACT_TICK, 10'($urandom));
         end else begin
            send_action(ACT_SAMPLE, pick_sample(1'b0));
         end
      end
   endtask

   task automatic noise_item();
      case ($urandom_range(0, 9))
         0, 1, 2, 3: send_action(ACT_SAMPLE, 10'($urandom));
         4, 5:       send_action(ACT_TICK, 10'($urandom));
         6:          send_action(ACT_TOGGLE, 10'($urandom));
         7:          send_action(ACT_NONE, 10'($urandom));
         default:    send_action(ACT_SAMPLE, pick_sample(1'b0));
      endcase
   endtask

   task automatic clap_episode();
      int unsigned k;
      repeat ($urandom_range(0, 4)) noise_item();
      send_action(ACT_SAMPLE, pick_sample(1'b1));
      if (ph == CODE_DEB1) begin
         if ($urandom_range(0, 7) == 0) send_action(ACT_SAMPLE, 10'($urandom));
         run_out_debounce();
         send_action(ACT_SAMPLE, pick_sample($urandom_range(0, 6) == 0));
         k = $urandom_range(0, 4);
         while (k != 0 && ph == CODE_WIN) begin
            repeat ($urandom_range(0, 3)) send_action(ACT_TICK, 10'($urandom));
            if (ph == CODE_WIN) begin
               send_action(ACT_SAMPLE, pick_sample(1'b1));
               if (ph == CODE_DEB2) begin
                  run_out_debounce();
                  send_action(ACT_SAMPLE, pick_sample($urandom_range(0, 9) == 0));
               end
            end
            k--;
         end
      end
      finish_window();
   endtask

   task automatic phase_run(int unsigned n);
      int unsigned start;
      start = items_sent;
      while (items_sent - start < n) clap_episode();
   endtask

   always @(negedge clock) begin
      if (style_left == 0) begin
         stall_style <= stall_style_type'($urandom_range(0, 3));
         style_left <= $urandom_range(20, 300);
      end else begin
         style_left <= style_left - 1;
      end
      case (stall_style)
         FLOW:    rsp_stall <= 1'b0;
         LIGHT:   rsp_stall <= ($urandom_range(0, 3) == 0);
         HEAVY:   rsp_stall <= ($urandom_range(0, 3) != 0);
         default: rsp_stall <= ~rsp_stall;
      endcase
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         toggles_seen += 32'(rsp_toggle_pulse);
         if (32'(rsp_clap_total) > peak_claps) peak_claps = 32'(rsp_clap_total);
         phases_seen[rsp_phase_now] = 1'b1;
         if (reports_due.size() == 0) begin
            $error("result transaction with no pending expectation");
            errors++;
         end else begin
            head = reports_due.pop_front();
            compare_field("toggle_pulse", 32'(head.toggle_pulse), 32'(rsp_toggle_pulse));
            compare_field("switch_on", 32'(head.switch_on), 32'(rsp_switch_on));
            compare_field("clap_total", 32'(head.clap_total), 32'(rsp_clap_total));
            compare_field("phase_now", 32'(head.phase_now), 32'(rsp_phase_now));
            compare_field("ambient_level", 32'(head.ambient_level),
                          32'(rsp_ambient_level));
         end
      end
   end

   initial begin
      logic [SAMPLE_W-1:0] smp;
      int unsigned pct, alpha, deb, win, need;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      write_setting(30, 14, 2, 12, 2);
      foreach (plan[i]) begin
         repeat (plan[i].reps) begin
            case (plan[i].kind)
               SMP_RAND:  smp = 10'($urandom_range(600, 0));
               SMP_LOUD:  smp = pick_sample(1'b1);
               SMP_QUIET: smp = pick_sample(1'b0);
               default:   smp = plan[i].smp;
            endcase
            send_action(plan[i].act, smp, plan[i].typed, plan[i].want);
         end
      end
      settle();

      // drive the clap count into saturation inside one window
      write_setting(99, 20, 0, 1, 127);
      send_action(ACT_SAMPLE, pick_sample(1'b1));
      if (ph == CODE_DEB1) send_action(ACT_SAMPLE, pick_sample(1'b0));
      repeat (130) begin
         if (ph == CODE_WIN) begin
            send_action(ACT_SAMPLE, pick_sample(1'b1));
            if (ph == CODE_DEB2) send_action(ACT_SAMPLE, pick_sample(1'b0));
         end
      end
      finish_window();
      settle();

      write_setting(127, 31, 255, 0, 0);
      repeat (3) clap_episode();
      settle();

      write_setting(1, 0, 1, 1, 127);
      phase_run(150);
      settle();

      repeat (8) begin
         pct = $urandom_range(0, 127);
         alpha = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 31) : $urandom_range(6, 18);
         deb = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         win = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 3) : $urandom_range(4, 60);
         need = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 127) : $urandom_range(0, 4);
         write_setting(pct, alpha, deb, win, need);
         phase_run(170);
         settle();
      end

      write_setting(30, 14, 30, 2000, 2);
      repeat (40) noise_item();
      settle();

      if (reports_due.size() != 0) begin
         $error("%0d expected results never arrived", reports_due.size());
         errors++;
      end
      $display("Covered %0d transactions under %0d register settings.",
               items_sent, settings_written);
      $display("Saw %0d switch toggles, peak clap count %0d, %0d distinct phases.",
               toggles_seen, peak_claps, $countones(phases_seen));
      if (errors == 0) begin
         $display("** adaptive_clap_counter_switch_top: PASSED **");
      end else begin
         $display("** adaptive_clap_counter_switch_top: FAILED **");
      end
      $finish;
   end

endmodule
